FILE: src/ssim_pkg.sv
`timescale 1ns / 1ps
package ssim_pkg;

  localparam int unsigned TickW = 64;
  localparam int unsigned ElemW = 16;

  typedef enum logic [1:0] {
    FuncRecord = 2'd0,
    FuncQuery  = 2'd1,
    FuncRead   = 2'd2,
    FuncClear  = 2'd3
  } func_e;

  typedef struct packed {
    logic [1:0]        func;
    logic [TickW-1:0]  tick_number;
    logic [7:0]        action_index;
    logic signed [ElemW-1:0] state_element;
    logic [3:0]        entry_index;
  } in_item_t;

  typedef struct packed {
    logic [15:0]       score;
    logic [3:0]        entry_position;
    logic [TickW-1:0]  entry_tick;
    logic [7:0]        entry_action;
    logic signed [ElemW-1:0] archived_element;
    logic              entry_valid;
    logic              last_result;
  } out_item_t;

endpackage

FILE: src/ssim_ram.sv
`timescale 1ns / 1ps
module ssim_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

FILE: src/snapshot_ring_similarity_scorer.sv
`timescale 1ns / 1ps
// Record, clear and non-final query elements: one transfer a cycle while no result is pending.
// A read then emits its DIM results one at a time via StRdWait and StRdOut, holding the input.
// A final query element holds the input until every entry's result is out, stalls included:
// per entry DIM accumulate steps, for a filled one two 22-step roots and a 59-step divide, then
// normalising divides, set by one shared bit-serial root/divide unit and one vector read port.
// Reset (asynchronous, active low) empties the ring and zeroes the threshold.
module snapshot_ring_similarity_scorer #(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned DIM     = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid,
  output logic                in_ready,
  input  ssim_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ssim_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [14:0]         cfg_data
);
  import ssim_pkg::*;

  localparam int unsigned EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned DW = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int unsigned AW = EW + DW;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned DCW = $clog2(DIM + 1);
  // Widths of the accumulators
  localparam int unsigned NW = 31 + $clog2(DIM + 1);   // sum of squares
  localparam int unsigned SW = NW + 8;                 // root operand
  localparam int unsigned RW = (SW + 1) / 2;           // root result
  localparam int unsigned PW = 2 * RW;                 // ra*rb
  localparam int unsigned QW = NW + 23;                // dividend
  localparam int unsigned TW = 16 + CW;                // total of sims

  typedef enum logic [3:0] {
    StIdle, StRdWait, StRdOut, StAcc, StAccLast, StRootA, StRootB, StMul,
    StDiv, StSim, StNormRd, StNormDiv, StOut
  } state_e;

  state_e               state_q;
  logic [14:0]          thr_q;
  logic [EW-1:0]        wp_q;
  logic [CW-1:0]        cnt_q;
  logic [DW-1:0]        ec_q;
  logic [1:0]           pf_q;
  logic signed [15:0]   probe_q [DIM];
  logic [15:0]          scr_q [ENTRIES];
  logic [TickW-1:0]     tick_q [ENTRIES];
  logic [7:0]           act_q [ENTRIES];

  logic [EW-1:0]        ent_q;     // logical entry
  logic [DCW-1:0]       j_q;       // element index
  logic [3:0]           rdidx_q;
  logic                 rdval_q;
  logic [EW-1:0]        slot_q;
  logic signed [NW:0]   dot_q;
  logic [NW-1:0]        na_q, nb_q;
  logic [SW-1:0]        rv_q;
  logic [RW-1:0]        rr_q, ra_q;
  logic [PW-1:0]        den_q;
  logic [QW-1:0]        rem_q, quo_q;
  logic [6:0]           step_q;
  logic [TW-1:0]        tot_q;
  out_item_t            out_q;
  logic                 ov_q;

  // vector archive
  logic                 vwe;
  logic [AW-1:0]        vwa, vra;
  logic [15:0]          vrd;

  ssim_ram #(.Width(16), .Depth(1 << AW)) u_vec (
    .clk_i  (clk_i),
    .we_i   (vwe),
    .waddr_i(vwa),
    .wdata_i(in_data.state_element),
    .raddr_i(vra),
    .rdata_o(vrd)
  );

  function automatic logic [EW-1:0] phys(input logic [EW-1:0] l, input logic [EW-1:0] w,
                                         input logic full);
    logic [EW:0] s;
    s = {1'b0, l} + {1'b0, w};
    if (!full) return l;
    if (s >= (EW+1)'(ENTRIES)) return EW'(s - (EW+1)'(ENTRIES));
    return s[EW-1:0];
  endfunction

  logic full;
  logic in_fire;
  logic [DCW-1:0] ec_eff;
  logic last_el;
  assign full    = (cnt_q == CW'(ENTRIES));
  assign in_ready  = (state_q == StIdle) && !ov_q;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = ov_q;
  assign out_data  = out_q;
  assign ec_eff    = (in_data.func != pf_q) ? '0 : DCW'(ec_q);
  assign last_el   = (ec_eff + 1'b1) >= DCW'(DIM);

  assign vwe = in_fire && (in_data.func == FuncRecord);
  assign vwa = {wp_q, ec_eff[DW-1:0]};
  assign vra = {slot_q, j_q[DW-1:0]};

  // shared step: root iteration (restoring, 2 bits a step) or division (1 bit a step)
  logic [RW+1:0]  trial;
  logic [QW:0]    div_t;
  always_comb begin
    trial = '0;
    div_t = '0;
    if (state_q == StRootA || state_q == StRootB) begin
      trial = {rem_q[RW-1:0], rv_q[SW-1 -: 2]} - {rr_q, 2'b01};
    end else begin
      div_t = {rem_q, quo_q[QW-1]} - {{(QW+1-PW){1'b0}}, den_q};
    end
  end

  logic signed [31:0] prod;
  logic signed [15:0] pa, pb;
  assign pa = probe_q[j_q[DW-1:0]];
  assign pb = vrd;
  logic [15:0] sim_v;
  logic        pass_v;

  always_comb begin
    prod = pa * pb;
    if (na_q == '0 || nb_q == '0 || dot_q[NW]) sim_v = '0;
    else sim_v = (quo_q > QW'(32768)) ? 16'd32768 : quo_q[15:0];
    pass_v = !dot_q[NW] && ({1'b0, sim_v} >= {2'b0, thr_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      thr_q   <= '0;
      wp_q    <= '0;
      cnt_q   <= '0;
      ec_q    <= '0;
      pf_q    <= '0;
      ov_q    <= 1'b0;
      ent_q   <= '0;
      j_q     <= '0;
      step_q  <= '0;
    end else begin
      if (cfg_valid) thr_q <= cfg_data;
      if (ov_q && out_ready) ov_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (in_fire) begin
            pf_q <= in_data.func;
            unique case (func_e'(in_data.func))
              FuncRecord: begin
                if (last_el) begin
                  tick_q[wp_q] <= in_data.tick_number;
                  act_q[wp_q]  <= in_data.action_index;
                  wp_q <= (wp_q == EW'(ENTRIES - 1)) ? '0 : wp_q + 1'b1;
                  if (!full) cnt_q <= cnt_q + 1'b1;
                  ec_q <= '0;
                end else ec_q <= DW'(ec_eff + 1'b1);
              end
              FuncQuery: begin
                probe_q[ec_eff[DW-1:0]] <= in_data.state_element;
                if (last_el) begin
                  ec_q  <= '0;
                  ent_q <= '0;
                  tot_q <= '0;
                  j_q   <= '0;
                  slot_q <= phys('0, wp_q, full);
                  state_q <= StAcc;
                  dot_q <= '0; na_q <= '0; nb_q <= '0;
                end else ec_q <= DW'(ec_eff + 1'b1);
              end
              FuncRead: begin
                ec_q <= '0;
                rdidx_q <= in_data.entry_index;
                rdval_q <= {{(CW > 4 ? CW-4 : 0){1'b0}}, in_data.entry_index} < cnt_q;
                slot_q <= ({{(CW > 4 ? CW-4 : 0){1'b0}}, in_data.entry_index} < cnt_q)
                          ? phys(EW'(in_data.entry_index), wp_q, full) : '0;
                j_q <= '0;
                state_q <= StRdWait;
              end
              FuncClear: begin
                wp_q <= '0; cnt_q <= '0; ec_q <= '0;
              end
              default: ;
            endcase
          end
        end
        StRdWait: state_q <= StRdOut;
        StRdOut: begin
          if (!ov_q) begin
            ov_q <= 1'b1;
            out_q.score <= '0;
            out_q.entry_position <= rdidx_q;
            out_q.entry_tick <= rdval_q ? tick_q[slot_q] : '0;
            out_q.entry_action <= rdval_q ? act_q[slot_q] : '0;
            out_q.archived_element <= rdval_q ? vrd : '0;
            out_q.entry_valid <= rdval_q;
            out_q.last_result <= (j_q == DCW'(DIM - 1));
            if (j_q == DCW'(DIM - 1)) state_q <= StIdle;
            else begin
              j_q <= j_q + 1'b1;
              state_q <= StRdWait;
            end
          end
        end
        StAcc: begin
          // read data for j_q lands next cycle
          state_q <= StAccLast;
        end
        StAccLast: begin
          dot_q <= dot_q + (NW+1)'(prod);
          na_q  <= na_q + NW'(unsigned'(32'(pa * pa)));
          nb_q  <= nb_q + NW'(unsigned'(32'(pb * pb)));
          if (j_q == DCW'(DIM - 1)) begin
            if (CW'(ent_q) >= cnt_q) begin
              scr_q[ent_q] <= '0;
              state_q <= (ent_q == EW'(ENTRIES - 1)) ? StNormRd : StAcc;
              ent_q <= (ent_q == EW'(ENTRIES - 1)) ? '0 : ent_q + 1'b1;
              slot_q <= phys(ent_q + 1'b1, wp_q, full);
              j_q <= '0;
              dot_q <= '0; na_q <= '0; nb_q <= '0;
            end else begin
              state_q <= StRootA;
              rv_q <= {na_q + NW'(unsigned'(32'(pa * pa))), 8'd0};
              rr_q <= '0; rem_q <= '0;
              step_q <= '0;
            end
          end else begin
            j_q <= j_q + 1'b1;
            state_q <= StAcc;
          end
        end
        StRootA, StRootB: begin
          rv_q <= rv_q << 2;
          if (!trial[RW+1]) begin
            rem_q <= QW'(trial);
            rr_q <= {rr_q[RW-2:0], 1'b1};
          end else begin
            rem_q <= QW'({rem_q[RW-1:0], rv_q[SW-1 -: 2]});
            rr_q <= {rr_q[RW-2:0], 1'b0};
          end
          if (step_q == 7'(RW - 1)) begin
            step_q <= '0;
            if (state_q == StRootA) begin
              ra_q <= trial[RW+1] ? {rr_q[RW-2:0], 1'b0} : {rr_q[RW-2:0], 1'b1};
              rv_q <= {nb_q, 8'd0};
              rr_q <= '0; rem_q <= '0;
              state_q <= StRootB;
            end else begin
              rr_q <= trial[RW+1] ? {rr_q[RW-2:0], 1'b0} : {rr_q[RW-2:0], 1'b1};
              state_q <= StMul;
            end
          end else step_q <= step_q + 1'b1;
        end
        StMul: begin
          den_q <= PW'(ra_q) * PW'(rr_q);
          rem_q <= '0;
          quo_q <= {dot_q[NW-1:0], 23'd0};
          step_q <= '0;
          state_q <= (na_q == '0 || nb_q == '0 || dot_q[NW]) ? StSim : StDiv;
        end
        StDiv: begin
          if (!div_t[QW]) begin
            rem_q <= div_t[QW-1:0];
            quo_q <= {quo_q[QW-2:0], 1'b1};
          end else begin
            rem_q <= {rem_q[QW-2:0], quo_q[QW-1]};
            quo_q <= {quo_q[QW-2:0], 1'b0};
          end
          if (step_q == 7'(QW - 1)) state_q <= StSim;
          step_q <= step_q + 1'b1;
        end
        StSim: begin
          if (pass_v) begin
            scr_q[ent_q] <= sim_v;
            tot_q <= tot_q + TW'(sim_v);
          end else scr_q[ent_q] <= '0;
          state_q <= (ent_q == EW'(ENTRIES - 1)) ? StNormRd : StAcc;
          ent_q <= (ent_q == EW'(ENTRIES - 1)) ? '0 : ent_q + 1'b1;
          slot_q <= phys(ent_q + 1'b1, wp_q, full);
          j_q <= '0;
          dot_q <= '0; na_q <= '0; nb_q <= '0;
        end
        StNormRd: begin
          // ent_q starts from 0 after wrapping; reuse divider: scr<<15 / total
          quo_q <= QW'({scr_q[ent_q], 15'd0}) << (QW - 31);
          rem_q <= '0;
          den_q <= PW'(tot_q);
          step_q <= '0;
          state_q <= StNormDiv;
        end
        StNormDiv: begin
          if (!div_t[QW]) begin
            rem_q <= div_t[QW-1:0];
            quo_q <= {quo_q[QW-2:0], 1'b1};
          end else begin
            rem_q <= {rem_q[QW-2:0], quo_q[QW-1]};
            quo_q <= {quo_q[QW-2:0], 1'b0};
          end
          if (step_q == 7'd30) state_q <= StOut;
          step_q <= step_q + 1'b1;
        end
        StOut: begin
          if (!ov_q) begin
            ov_q <= 1'b1;
            out_q.score <= (tot_q == '0) ? '0 : quo_q[15:0];
            out_q.entry_position <= 4'(ent_q);
            out_q.entry_tick <= (CW'(ent_q) < cnt_q) ? tick_q[phys(ent_q, wp_q, full)] : '0;
            out_q.entry_action <= (CW'(ent_q) < cnt_q) ? act_q[phys(ent_q, wp_q, full)] : '0;
            out_q.archived_element <= '0;
            out_q.entry_valid <= (CW'(ent_q) < cnt_q);
            out_q.last_result <= (ent_q == EW'(ENTRIES - 1));
            ent_q <= ent_q + 1'b1;
            state_q <= (ent_q == EW'(ENTRIES - 1)) ? StIdle : StNormRd;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import ssim_pkg::*;

  localparam int unsigned NENT = 16;
  localparam int unsigned NDIM = 16;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned ITEMS_PER_PHASE = 90;

  class ring_score_tracker;
    logic [14:0]        threshold;
    logic [63:0]        ticks[NENT];
    logic [7:0]         actions[NENT];
    logic signed [15:0] archive[NENT][NDIM];
    logic signed [15:0] probe[NDIM];
    int unsigned        wr_ptr;
    int unsigned        filled;
    int unsigned        elem_idx;
    func_e              prev_func;
    out_item_t          expected[$];
    int unsigned        mismatches;

    function new();
      threshold   = '0;
      wr_ptr      = 0;
      filled      = 0;
      elem_idx    = 0;
      prev_func   = FuncRecord;
      mismatches  = 0;
    endfunction

    function int unsigned slot_of(int unsigned logical);
      if (filled < NENT) return logical;
      return (wr_ptr + logical) % NENT;
    endfunction

    function longint unsigned root_down(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // Cosine similarity in Q1.15 against the held probe, with the threshold gate.
    function void cosine(int unsigned slot, output longint unsigned sim, output bit ok);
      longint            dot;
      longint unsigned   na;
      longint unsigned   nb;
      longint unsigned   q;
      longint            a;
      longint            b;
      dot = 0;
      na  = 0;
      nb  = 0;
      for (int j = 0; j < NDIM; j++) begin
        a = longint'(probe[j]);
        b = longint'(archive[slot][j]);
        dot += a * b;
        na  += longint'(a * a);
        nb  += longint'(b * b);
      end
      if (na == 0 || nb == 0) begin
        sim = 0;
        ok  = (threshold == 0);
        return;
      end
      if (dot < 0) begin
        sim = 0;
        ok  = 1'b0;
        return;
      end
      q = (longint'(dot) << 23) / (root_down(na << 8) * root_down(nb << 8));
      if (q > 32768) q = 32768;
      sim = q;
      ok  = (q >= threshold);
    endfunction

    function void note_item(in_item_t it);
      func_e           f;
      longint unsigned sims[NENT];
      bit              pass[NENT];
      longint unsigned total;
      out_item_t       o;
      int unsigned     slot;
      f = func_e'(it.func);
      if (f != prev_func) elem_idx = 0;
      prev_func = f;
      case (f)
        FuncRecord: begin
          archive[wr_ptr][elem_idx] = it.state_element;
          if (elem_idx + 1 >= NDIM) begin
            ticks[wr_ptr]   = it.tick_number;
            actions[wr_ptr] = it.action_index;
            wr_ptr = (wr_ptr + 1) % NENT;
            if (filled < NENT) filled++;
            elem_idx = 0;
          end else begin
            elem_idx++;
          end
        end
        FuncQuery: begin
          probe[elem_idx] = it.state_element;
          if (elem_idx + 1 >= NDIM) begin
            elem_idx = 0;
            total = 0;
            for (int i = 0; i < NENT; i++) begin
              pass[i] = 1'b0;
              sims[i] = 0;
              if (i < filled) begin
                cosine(slot_of(i), sims[i], pass[i]);
                if (pass[i]) total += sims[i];
              end
            end
            for (int i = 0; i < NENT; i++) begin
              o = '0;
              o.entry_position = 4'(i);
              if (i < filled) begin
                slot = slot_of(i);
                o.entry_tick   = ticks[slot];
                o.entry_action = actions[slot];
                o.entry_valid  = 1'b1;
                if (pass[i] && total > 0) o.score = 16'((sims[i] << 15) / total);
              end
              o.last_result = (i == NENT - 1);
              expected.push_back(o);
            end
          end else begin
            elem_idx++;
          end
        end
        FuncRead: begin
          for (int i = 0; i < NDIM; i++) begin
            o = '0;
            o.entry_position = it.entry_index;
            if (it.entry_index < filled) begin
              slot = slot_of(it.entry_index);
              o.entry_tick       = ticks[slot];
              o.entry_action     = actions[slot];
              o.archived_element = archive[slot][i];
              o.entry_valid      = 1'b1;
            end
            o.last_result = (i == NDIM - 1);
            expected.push_back(o);
          end
        end
        default: begin
          wr_ptr   = 0;
          filled   = 0;
          elem_idx = 0;
        end
      endcase
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("mismatch: %s", what);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (expected.size() == 0) begin
        report_mismatch($sformatf("unexpected result %p", got));
        return;
      end
      want = expected.pop_front();
      if (got.score !== want.score)
        report_mismatch($sformatf("score %0d, want %0d", got.score, want.score));
      if (got.entry_position !== want.entry_position)
        report_mismatch($sformatf("position %0d, want %0d",
                                  got.entry_position, want.entry_position));
      if (got.entry_tick !== want.entry_tick)
        report_mismatch($sformatf("tick %h, want %h", got.entry_tick, want.entry_tick));
      if (got.entry_action !== want.entry_action)
        report_mismatch($sformatf("action %0d, want %0d",
                                  got.entry_action, want.entry_action));
      if (got.archived_element !== want.archived_element)
        report_mismatch($sformatf("element %0d, want %0d",
                                  got.archived_element, want.archived_element));
      if (got.entry_valid !== want.entry_valid)
        report_mismatch($sformatf("valid %b, want %b", got.entry_valid, want.entry_valid));
      if (got.last_result !== want.last_result)
        report_mismatch($sformatf("last %b, want %b", got.last_result, want.last_result));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [14:0] cfg_data;

  ring_score_tracker  tracker;
  int unsigned        cycles;
  int unsigned        items_sent;
  int unsigned        burst_left;
  bit                 steady_send;
  bit                 steady_ready;
  logic [15:0]        ready_pattern;
  logic [3:0]         pattern_pos;
  logic signed [15:0] vec[NDIM];
  logic signed [15:0] last_vec[NDIM];

  snapshot_ring_similarity_scorer dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("snapshot_ring_similarity_scorer regression: fail");
      $finish;
    end
  end

  // Unless steady_ready is set, receiver stalls follow a pattern that is reshuffled when pattern_pos wraps.
  always @(posedge clk_i) begin
    pattern_pos <= pattern_pos + 1'b1;
    out_ready   <= steady_ready ? 1'b1 : ready_pattern[pattern_pos];
    if (pattern_pos == 4'hF) ready_pattern <= 16'($urandom);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) tracker.check_result(out_data);
  end

  task automatic push_item(in_item_t it);
    int unsigned gap;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (!in_ready);
    tracker.note_item(it);
    items_sent++;
    if (!steady_send) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 5);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_stream(func_e f, int unsigned len);
    in_item_t it;
    for (int j = 0; j < len; j++) begin
      it.func          = f;
      it.tick_number   = {$urandom, $urandom};
      it.action_index  = 8'($urandom);
      it.state_element = vec[j];
      it.entry_index   = 4'($urandom);
      push_item(it);
    end
  endtask

  task automatic send_single(func_e f, logic [3:0] idx);
    in_item_t it;
    it.func          = f;
    it.tick_number   = {$urandom, $urandom};
    it.action_index  = 8'($urandom);
    it.state_element = 16'($urandom);
    it.entry_index   = idx;
    push_item(it);
  endtask

  // Fill vec: mostly near the last recorded vector, so scores pass high thresholds.
  task automatic make_vector(int unsigned kind);
    for (int j = 0; j < NDIM; j++) begin
      case (kind)
        0: vec[j] = 16'($urandom);
        1: vec[j] = last_vec[j] + $signed(16'($urandom_range(0, 64))) - 16'sd32;
        2: vec[j] = -last_vec[j];
        3: vec[j] = '0;
        4: vec[j] = $signed(16'($urandom_range(0, 16))) - 16'sd8;
        default: vec[j] = ($urandom_range(0, 1) == 1) ? 16'sh7FFF : 16'sh8000;
      endcase
    end
  endtask

  task automatic write_threshold(logic [14:0] value);
    in_valid <= 1'b0;
    while (tracker.expected.size() != 0) @(posedge clk_i);
    // Let a trailing record or clear transfer settle before touching the register.
    repeat (20) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    tracker.threshold = value;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [14:0] thresholds[5];
    int unsigned pick;
    tracker       = new();
    cycles        = 0;
    items_sent    = 0;
    burst_left    = 4;
    steady_send   = 1'b0;
    steady_ready  = 1'b1;
    ready_pattern = 16'hA5F3;
    pattern_pos   = '0;
    rst_ni        = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_ready     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    for (int j = 0; j < NDIM; j++) last_vec[j] = 16'($urandom);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extreme record, valid and empty reads, clear, read after clear.
    write_threshold(15'd0);
    for (int j = 0; j < NDIM; j++)
      vec[j] = (j % 3 == 0) ? 16'sh7FFF : (j % 3 == 1) ? 16'sh8000 : 16'sh0;
    begin
      in_item_t it;
      for (int j = 0; j < NDIM; j++) begin
        it.func          = FuncRecord;
        it.tick_number   = '1;
        it.action_index  = 8'hFF;
        it.state_element = vec[j];
        it.entry_index   = 4'hF;
        push_item(it);
      end
    end
    send_single(FuncRead, 4'd0);
    send_single(FuncRead, 4'd15);
    send_single(FuncClear, 4'd0);
    send_single(FuncRead, 4'd0);

    thresholds[0] = 15'd0;
    thresholds[1] = 15'd32767;
    thresholds[2] = 15'($urandom);
    thresholds[3] = 15'd1;
    thresholds[4] = 15'd24000;
    for (int ph = 0; ph < 5; ph++) begin
      write_threshold(thresholds[ph]);
      steady_send  = (ph == 2);
      steady_ready = (ph == 3);
      while (items_sent < (ph + 1) * ITEMS_PER_PHASE + 20) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          make_vector(($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : 1);
          send_stream(FuncRecord, NDIM);
          last_vec = vec;
        end else if (pick < 65) begin
          make_vector($urandom_range(0, 9) < 5 ? 1 : $urandom_range(0, 5));
          send_stream(FuncQuery, NDIM);
        end else if (pick < 80) begin
          send_single(FuncRead, 4'($urandom));
        end else if (pick < 84) begin
          send_single(FuncClear, 4'($urandom));
        end else begin
          make_vector(0);
          send_stream(($urandom_range(0, 1) == 1) ? FuncQuery : FuncRecord,
                      $urandom_range(1, NDIM - 1));
        end
      end
    end

    in_valid <= 1'b0;
    while (tracker.expected.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.expected.size() == 0) begin
      $display("snapshot_ring_similarity_scorer regression: pass");
    end else begin
      $display("snapshot_ring_similarity_scorer regression: fail");
    end
    $finish;
  end
endmodule

FILE: sim.f
src/ssim_pkg.sv
src/ssim_ram.sv
src/snapshot_ring_similarity_scorer.sv
verif/testbench.sv
